>>> rtl/sab_pkg.sv
`default_nettype none
package sab_pkg;

	localparam int SYMBOL_W = 8;
	localparam int NODE_W   = 9;
	localparam int LEN_W    = 9;
	localparam int COUNT_W  = 16;
	localparam int NCOUNT_W = 10;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 56;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_REDUCE,
		OP_START,
		OP_RD_T,
		OP_GOT_T,
		OP_W1_RD,
		OP_W1_CHK,
		OP_QL_P,
		OP_QL_Q,
		OP_QCMP,
		OP_PC_RD,
		OP_PC_WR,
		OP_CL_LRD,
		OP_CL_LWR,
		OP_COPY,
		OP_L2_RD,
		OP_L2_CHK,
		OP_FIN_Q,
		OP_FIN_CUR,
		OP_EMIT_RD,
		OP_EMIT
	} op_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REDUCE,
		ST_START,
		ST_RD_T,
		ST_GOT_T,
		ST_W1_RD,
		ST_W1_CHK,
		ST_QL_P,
		ST_QL_Q,
		ST_QCMP,
		ST_PC_RD,
		ST_PC_WR,
		ST_CL_LRD,
		ST_CL_LWR,
		ST_COPY,
		ST_L2_RD,
		ST_L2_CHK,
		ST_FIN_Q,
		ST_FIN_CUR,
		ST_EMIT_RD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clear_done;
		logic sym_ok;
		logic full;
		logic t_zero;
		logic t_eq_q;
		logic p_root;
		logic len_match;
		logic q_is_cur;
		logic copy_done;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

>>> rtl/sab_ctrl.sv
`default_nettype none
module sab_ctrl
	import sab_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire status_t status,
	output logic         in_ready,
	output op_t          op
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR:   if (status.clear_done) state_nxt = ST_IDLE;
			ST_IDLE:    if (in_valid) state_nxt = ST_REDUCE;
			ST_REDUCE: begin
				if (status.sym_ok) state_nxt = status.full ? ST_EMIT_RD : ST_START;
			end
			ST_START:   state_nxt = ST_RD_T;
			ST_RD_T:    state_nxt = ST_GOT_T;
			ST_GOT_T:   state_nxt = ST_W1_RD;
			ST_W1_RD:   state_nxt = ST_W1_CHK;
			ST_W1_CHK: begin
				priority if (!status.t_zero) state_nxt = ST_QL_P;
				else if (status.p_root)      state_nxt = ST_EMIT_RD;
				else                         state_nxt = ST_W1_RD;
			end
			ST_QL_P:    state_nxt = ST_QL_Q;
			ST_QL_Q:    state_nxt = ST_QCMP;
			ST_QCMP: begin
				priority if (!status.len_match) state_nxt = ST_CL_LRD;
				else if (status.q_is_cur)       state_nxt = ST_PC_RD;
				else                            state_nxt = ST_EMIT_RD;
			end
			ST_PC_RD:   state_nxt = ST_PC_WR;
			ST_PC_WR:   state_nxt = ST_EMIT_RD;
			ST_CL_LRD:  state_nxt = ST_CL_LWR;
			ST_CL_LWR:  state_nxt = ST_COPY;
			ST_COPY:    if (status.copy_done) state_nxt = ST_L2_RD;
			ST_L2_RD:   state_nxt = ST_L2_CHK;
			ST_L2_CHK: begin
				if (!status.t_eq_q || status.p_root) state_nxt = ST_FIN_Q;
				else                                 state_nxt = ST_L2_RD;
			end
			ST_FIN_Q:   state_nxt = ST_FIN_CUR;
			ST_FIN_CUR: state_nxt = ST_EMIT_RD;
			ST_EMIT_RD: state_nxt = ST_EMIT;
			ST_EMIT:    if (status.out_free) state_nxt = ST_IDLE;
			default:    state_nxt = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		op       = OP_NONE;
		unique case (state_q)
			ST_CLEAR:   op = OP_CLEAR;
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) op = OP_LOAD;
			end
			ST_REDUCE:  op = OP_REDUCE;
			ST_START:   op = OP_START;
			ST_RD_T:    op = OP_RD_T;
			ST_GOT_T:   op = OP_GOT_T;
			ST_W1_RD:   op = OP_W1_RD;
			ST_W1_CHK:  op = OP_W1_CHK;
			ST_QL_P:    op = OP_QL_P;
			ST_QL_Q:    op = OP_QL_Q;
			ST_QCMP:    op = OP_QCMP;
			ST_PC_RD:   op = OP_PC_RD;
			ST_PC_WR:   op = OP_PC_WR;
			ST_CL_LRD:  op = OP_CL_LRD;
			ST_CL_LWR:  op = OP_CL_LWR;
			ST_COPY:    op = OP_COPY;
			ST_L2_RD:   op = OP_L2_RD;
			ST_L2_CHK:  op = OP_L2_CHK;
			ST_FIN_Q:   op = OP_FIN_Q;
			ST_FIN_CUR: op = OP_FIN_CUR;
			ST_EMIT_RD: op = OP_EMIT_RD;
			ST_EMIT:    op = OP_EMIT;
			default:    op = OP_NONE;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/sab_dp.sv
`default_nettype none
module sab_dp
	import sab_pkg::*;
#(
	parameter int MAX_NODES = 512,
	parameter int ALPHABET  = 256
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire op_t                   op,
	input  wire logic [SYMBOL_W-1:0]   in_symbol,
	input  wire logic                  in_use_base,
	input  wire logic [NODE_W-1:0]     in_base_node,
	input  wire logic                  out_ready,
	output status_t                    status,
	output logic                       out_valid,
	output logic [NODE_W-1:0]          last_node,
	output logic [LEN_W-1:0]           last_len,
	output logic [NODE_W-1:0]          last_link,
	output logic [COUNT_W-1:0]         prefix_count,
	output logic [NCOUNT_W-1:0]        node_count,
	output logic                       full_res
);

	localparam int NW     = $clog2(MAX_NODES);
	localparam int CW     = $clog2(MAX_NODES + 1);
	localparam int AW     = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
	localparam int TW     = NW + AW;
	localparam int TDEPTH = MAX_NODES * (2 ** AW);
	localparam int KW     = AW + 1;
	localparam int BW     = (CW > NODE_W) ? CW : NODE_W;

	logic [NW-1:0]      trans_mem [TDEPTH];
	logic [NW-1:0]      len_mem   [MAX_NODES];
	logic [NW-1:0]      link_mem  [MAX_NODES];
	logic [COUNT_W-1:0] pc_mem    [MAX_NODES];

	logic [NW-1:0]      trans_rd_q, len_rd_q, link_rd_q;
	logic [COUNT_W-1:0] pc_rd_q;

	logic               trans_we, trans_re, len_we, len_re, link_we, link_re, pc_we, pc_re;
	logic [TW-1:0]      trans_wa, trans_ra;
	logic [NW-1:0]      trans_wd, len_wa, len_ra, len_wd, link_wa, link_ra, link_wd;
	logic [NW-1:0]      pc_wa, pc_ra;
	logic [COUNT_W-1:0] pc_wd;

	logic [SYMBOL_W-1:0] c_q;
	logic                use_base_q, refused_q;
	logic [NODE_W-1:0]   base_q;
	logic [NW-1:0]       end_q, p_q, cur_q, q_q, cl_q, lenp_q;
	logic [CW-1:0]       nodes_q;
	logic [KW-1:0]       k_q;
	logic [TW-1:0]       clr_q;

	logic [AW-1:0] c_idx;
	logic [NW-1:0] nodes_idx, start_node;
	logic [KW-1:0] k_prev;

	assign c_idx     = c_q[AW-1:0];
	assign nodes_idx = nodes_q[NW-1:0];
	assign k_prev    = k_q - 1'b1;
	assign start_node = !use_base_q ? end_q :
		((BW'(base_q) < BW'(nodes_q)) ? NW'(base_q) : '0);

	always_comb begin
		status.clear_done = (clr_q == TW'(TDEPTH - 1));
		status.sym_ok     = ({1'b0, c_q} < (SYMBOL_W + 1)'(ALPHABET));
		status.full       = (nodes_q > CW'(MAX_NODES - 2));
		status.t_zero     = (trans_rd_q == '0);
		status.t_eq_q     = (trans_rd_q == q_q);
		status.p_root     = (p_q == '0);
		status.len_match  = (({1'b0, lenp_q} + 1'b1) == {1'b0, len_rd_q});
		status.q_is_cur   = (q_q == cur_q);
		status.copy_done  = (k_q == KW'(ALPHABET));
		status.out_free   = !out_valid || out_ready;
	end

	// memory port steering per operation
	always_comb begin
		trans_we = 1'b0; trans_wa = '0; trans_wd = '0; trans_re = 1'b0; trans_ra = '0;
		len_we   = 1'b0; len_wa   = '0; len_wd   = '0; len_re   = 1'b0; len_ra   = '0;
		link_we  = 1'b0; link_wa  = '0; link_wd  = '0; link_re  = 1'b0; link_ra  = '0;
		pc_we    = 1'b0; pc_wa    = '0; pc_wd    = '0; pc_re    = 1'b0; pc_ra    = '0;
		unique case (op)
			OP_CLEAR: begin
				trans_we = 1'b1;
				trans_wa = clr_q;
				if (clr_q == '0) begin
					len_we = 1'b1;
					pc_we  = 1'b1;
					pc_wd  = COUNT_W'(1);
				end
			end
			OP_RD_T: begin
				trans_re = 1'b1; trans_ra = {p_q, c_idx};
				len_re   = 1'b1; len_ra   = p_q;
			end
			OP_GOT_T: begin
				if (trans_rd_q == '0) begin
					len_we  = 1'b1; len_wa  = nodes_idx; len_wd = NW'(len_rd_q + 1'b1);
					link_we = 1'b1; link_wa = nodes_idx;
					pc_we   = 1'b1; pc_wa   = nodes_idx; pc_wd  = COUNT_W'(1);
				end
			end
			OP_W1_RD, OP_L2_RD: begin
				trans_re = 1'b1; trans_ra = {p_q, c_idx};
				link_re  = 1'b1; link_ra  = p_q;
			end
			OP_W1_CHK: begin
				if (trans_rd_q == '0) begin
					trans_we = 1'b1; trans_wa = {p_q, c_idx}; trans_wd = cur_q;
					if (p_q == '0) begin
						link_we = 1'b1; link_wa = cur_q;
					end
				end
			end
			OP_QL_P: begin
				len_re = 1'b1; len_ra = p_q;
			end
			OP_QL_Q: begin
				len_re = 1'b1; len_ra = q_q;
			end
			OP_QCMP: begin
				if (status.len_match) begin
					if (q_q != cur_q) begin
						link_we = 1'b1; link_wa = cur_q; link_wd = q_q;
					end
				end else begin
					len_we = 1'b1; len_wa = nodes_idx; len_wd = NW'(lenp_q + 1'b1);
					pc_we  = 1'b1; pc_wa  = nodes_idx;
					pc_wd  = (q_q == cur_q) ? COUNT_W'(1) : '0;
				end
			end
			OP_PC_RD: begin
				pc_re = 1'b1; pc_ra = cur_q;
			end
			OP_PC_WR: begin
				if (pc_rd_q != COUNT_MAX) begin
					pc_we = 1'b1; pc_wa = cur_q; pc_wd = pc_rd_q + 1'b1;
				end
			end
			OP_CL_LRD: begin
				link_re = 1'b1; link_ra = q_q;
			end
			OP_CL_LWR: begin
				link_we = 1'b1; link_wa = cl_q; link_wd = link_rd_q;
			end
			OP_COPY: begin
				// read entry k of the source row while writing entry k-1 of the clone
				if (!status.copy_done) begin
					trans_re = 1'b1; trans_ra = {q_q, k_q[AW-1:0]};
				end
				if (k_q != '0) begin
					trans_we = 1'b1; trans_wa = {cl_q, k_prev[AW-1:0]}; trans_wd = trans_rd_q;
				end
			end
			OP_L2_CHK: begin
				if (trans_rd_q == q_q) begin
					trans_we = 1'b1; trans_wa = {p_q, c_idx}; trans_wd = cl_q;
				end
			end
			OP_FIN_Q: begin
				link_we = 1'b1; link_wa = q_q; link_wd = cl_q;
			end
			OP_FIN_CUR: begin
				link_we = 1'b1; link_wa = cur_q; link_wd = cl_q;
			end
			OP_EMIT_RD: begin
				len_re  = 1'b1; len_ra  = end_q;
				link_re = 1'b1; link_ra = end_q;
				pc_re   = 1'b1; pc_ra   = end_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (trans_we) trans_mem[trans_wa] <= trans_wd;
		if (trans_re) trans_rd_q <= trans_mem[trans_ra];
	end

	always_ff @(posedge clk) begin
		if (len_we) len_mem[len_wa] <= len_wd;
		if (len_re) len_rd_q <= len_mem[len_ra];
	end

	always_ff @(posedge clk) begin
		if (link_we) link_mem[link_wa] <= link_wd;
		if (link_re) link_rd_q <= link_mem[link_ra];
	end

	always_ff @(posedge clk) begin
		if (pc_we) pc_mem[pc_wa] <= pc_wd;
		if (pc_re) pc_rd_q <= pc_mem[pc_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			end_q     <= '0;
			nodes_q   <= CW'(1);
			out_valid <= 1'b0;
		end else begin
			if (op == OP_CLEAR && !status.clear_done) clr_q <= clr_q + 1'b1;
			unique case (op)
				OP_START: end_q <= start_node;
				OP_GOT_T: begin
					if (trans_rd_q == '0) begin
						end_q   <= nodes_idx;
						nodes_q <= nodes_q + 1'b1;
					end else begin
						end_q <= trans_rd_q;
					end
				end
				OP_QCMP: begin
					if (!status.len_match) begin
						nodes_q <= nodes_q + 1'b1;
						if (q_q == cur_q) end_q <= nodes_idx;
					end
				end
				default: begin
				end
			endcase
			if (op == OP_EMIT && status.out_free) out_valid <= 1'b1;
			else if (out_ready)                  out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				c_q        <= in_symbol;
				use_base_q <= in_use_base;
				base_q     <= in_base_node;
				refused_q  <= 1'b0;
			end
			OP_REDUCE: begin
				if (!status.sym_ok) c_q <= c_q - SYMBOL_W'(ALPHABET);
				else                refused_q <= status.full;
			end
			OP_START: p_q <= start_node;
			OP_GOT_T: cur_q <= (trans_rd_q == '0) ? nodes_idx : trans_rd_q;
			OP_W1_CHK: begin
				if (trans_rd_q != '0) q_q <= trans_rd_q;
				else if (p_q != '0)   p_q <= link_rd_q;
			end
			OP_QL_Q: lenp_q <= len_rd_q;
			OP_QCMP: begin
				cl_q <= nodes_idx;
				k_q  <= '0;
			end
			OP_COPY: k_q <= k_q + 1'b1;
			OP_L2_CHK: begin
				if (trans_rd_q == q_q && p_q != '0) p_q <= link_rd_q;
			end
			OP_EMIT: begin
				if (status.out_free) begin
					last_node    <= NODE_W'(end_q);
					last_len     <= LEN_W'(len_rd_q);
					last_link    <= (end_q == '0) ? '0 : NODE_W'(link_rd_q);
					prefix_count <= pc_rd_q;
					node_count   <= NCOUNT_W'(nodes_q);
					full_res     <= refused_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/suffix_automaton_builder.sv
// Per word: a first walk along suffix links until a transition is found or the root is reached;
// then an existing target is checked (its prefix count may rise), or it is cloned, which copies
// all ALPHABET transitions and runs a second suffix-link walk; a refused word skips all of these.
// Throughput: one word at a time; s_tready returns as the result is registered, and a result
// still waiting on m_tready holds the block.
// Reset: async, active low; a pass then clears all MAX_NODES * 2**clog2(ALPHABET) transitions.
`default_nettype none
module suffix_automaton_builder
	import sab_pkg::*;
#(
	parameter int MAX_NODES = 512,
	parameter int ALPHABET  = 256
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,  // symbol[7:0], base_node[16:8]
	input  wire logic                s_tuser,  // use_base
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata,  // last_node, last_len, last_link,
	                                           // prefix_count, node_count
	output logic                     m_tuser   // full_res
);

	op_t     op;
	status_t status;

	logic [NODE_W-1:0]   last_node, last_link;
	logic [LEN_W-1:0]    last_len;
	logic [COUNT_W-1:0]  prefix_count;
	logic [NCOUNT_W-1:0] node_count;

	sab_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.status   (status),
		.in_ready (s_tready),
		.op       (op)
	);

	sab_dp #(
		.MAX_NODES (MAX_NODES),
		.ALPHABET  (ALPHABET)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.in_symbol    (s_tdata[7:0]),
		.in_use_base  (s_tuser),
		.in_base_node (s_tdata[16:8]),
		.out_ready    (m_tready),
		.status       (status),
		.out_valid    (m_tvalid),
		.last_node    (last_node),
		.last_len     (last_len),
		.last_link    (last_link),
		.prefix_count (prefix_count),
		.node_count   (node_count),
		.full_res     (m_tuser)
	);

	assign m_tdata = {3'b000, node_count, prefix_count, last_link, last_len, last_node};

endmodule
`default_nettype wire
